// ----- src/sfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame deframer package
// Shared types, codes and constants of the sensor frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int PayloadBytes = 20;
  localparam int WordCount    = PayloadBytes / 4;
  localparam int IdxW         = $clog2(PayloadBytes);
  localparam int CfgIdxW      = 2;

  localparam int OpQueueDepthDefault  = 2;
  localparam int ResQueueDepthDefault = 2;

  localparam logic [7:0] HeaderFirstReset  = 8'hAA;
  localparam logic [7:0] HeaderSecondReset = 8'h55;
  localparam logic [7:0] TailFirstReset    = 8'h55;
  localparam logic [7:0] TailSecondReset   = 8'hAA;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER_FIRST  = 2'd0,
    CFG_HEADER_SECOND = 2'd1,
    CFG_TAIL_FIRST    = 2'd2,
    CFG_TAIL_SECOND   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_CSUM  = 2'd1,
    OP_TAIL1 = 2'd2,
    OP_TAIL2 = 2'd3
  } op_kind_e;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_TAIL = 2'd1,
    ST_BAD_SUM  = 2'd2
  } status_e;

  typedef struct packed {
    op_kind_e        kind;
    logic [7:0]      data;
    logic [IdxW-1:0] idx;
  } op_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } in_t;

  typedef struct packed {
    logic [31:0] air_temperature;
    logic [31:0] air_humidity;
    logic [31:0] soil_temperature;
    logic [31:0] soil_humidity;
    logic [31:0] light_level;
    logic [1:0]  frame_status;
  } out_t;

endpackage

// ----- src/sfd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame deframer queue
// Small first-in first-out queue with registered storage and a fill count.
// ----------------------------------------------------------------------------
module sfd_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- src/sfd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame deframer front end
// Hunts for the header and classifies each later byte of a frame into an op.
// ----------------------------------------------------------------------------
module sfd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_take_i,
  input  sfd_pkg::in_t      in_data_i,
  input  logic [7:0]        header_first_i,
  input  logic [7:0]        header_second_i,
  output logic              op_valid_o,
  output sfd_pkg::op_t      op_o
);

  localparam logic [2:0] PH_HUNT1   = 3'd0;
  localparam logic [2:0] PH_HUNT2   = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_CSUM    = 3'd3;
  localparam logic [2:0] PH_TAIL1   = 3'd4;
  localparam logic [2:0] PH_TAIL2   = 3'd5;

  localparam int IdxW = sfd_pkg::IdxW;

  logic [2:0]      phase_q, phase_d;
  logic [IdxW-1:0] count_q, count_d;
  logic [7:0]      b;

  assign b = in_data_i.rx_byte;

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    op_valid_o = 1'b0;
    op_o.kind  = sfd_pkg::OP_DATA;
    op_o.data  = b;
    op_o.idx   = count_q;
    if (in_take_i) begin
      case (phase_q)
        PH_HUNT1: begin
          if (b == header_first_i) begin
            phase_d = PH_HUNT2;
          end
        end
        PH_HUNT2: begin
          if (b == header_second_i) begin
            phase_d = PH_PAYLOAD;
            count_d = '0;
          end else if (b != header_first_i) begin
            phase_d = PH_HUNT1;
          end
        end
        PH_PAYLOAD: begin
          op_valid_o = 1'b1;
          op_o.kind  = sfd_pkg::OP_DATA;
          count_d    = count_q + 1'b1;
          if (count_q == IdxW'(sfd_pkg::PayloadBytes - 1)) begin
            phase_d = PH_CSUM;
          end
        end
        PH_CSUM: begin
          op_valid_o = 1'b1;
          op_o.kind  = sfd_pkg::OP_CSUM;
          phase_d    = PH_TAIL1;
        end
        PH_TAIL1: begin
          op_valid_o = 1'b1;
          op_o.kind  = sfd_pkg::OP_TAIL1;
          phase_d    = PH_TAIL2;
        end
        PH_TAIL2: begin
          op_valid_o = 1'b1;
          op_o.kind  = sfd_pkg::OP_TAIL2;
          phase_d    = PH_HUNT1;
          count_d    = '0;
        end
        default: begin
          phase_d = PH_HUNT1;
        end
      endcase
      if (in_data_i.buffer_end) begin
        phase_d = PH_HUNT1;
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

endmodule

// ----- src/sfd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame deframer back end
// Stores the payload, keeps the checksum and builds the result of a frame.
// ----------------------------------------------------------------------------
module sfd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  input  sfd_pkg::op_t      op_i,
  output logic              op_pop_o,
  input  logic [7:0]        tail_first_i,
  input  logic [7:0]        tail_second_i,
  input  logic              res_full_i,
  output logic              res_push_o,
  output sfd_pkg::out_t     res_o
);

  logic [7:0] store_q [sfd_pkg::PayloadBytes];
  logic [7:0] xor_q, xor_d;
  logic [7:0] sum_q, sum_d;
  logic       tail_ok_q, tail_ok_d;
  logic       is_tail2;
  logic [31:0] words [sfd_pkg::WordCount];

  assign is_tail2   = (op_i.kind == sfd_pkg::OP_TAIL2);
  assign op_pop_o   = op_valid_i && (!is_tail2 || !res_full_i);
  assign res_push_o = op_valid_i && is_tail2 && !res_full_i;

  always_comb begin
    for (int j = 0; j < sfd_pkg::WordCount; j++) begin
      words[j] = {store_q[4*j+3], store_q[4*j+2], store_q[4*j+1], store_q[4*j]};
    end
  end

  always_comb begin
    res_o.air_temperature  = words[0];
    res_o.air_humidity     = words[1];
    res_o.soil_temperature = words[2];
    res_o.soil_humidity    = words[3];
    res_o.light_level      = words[4];
    if (!(tail_ok_q && op_i.data == tail_second_i)) begin
      res_o.frame_status = sfd_pkg::ST_BAD_TAIL;
    end else if (xor_q != sum_q) begin
      res_o.frame_status = sfd_pkg::ST_BAD_SUM;
    end else begin
      res_o.frame_status = sfd_pkg::ST_GOOD;
    end
  end

  always_comb begin
    xor_d     = xor_q;
    sum_d     = sum_q;
    tail_ok_d = tail_ok_q;
    if (op_pop_o) begin
      case (op_i.kind)
        sfd_pkg::OP_DATA: begin
          xor_d = (op_i.idx == '0) ? op_i.data : (xor_q ^ op_i.data);
        end
        sfd_pkg::OP_CSUM: begin
          sum_d = op_i.data;
        end
        sfd_pkg::OP_TAIL1: begin
          tail_ok_d = (op_i.data == tail_first_i);
        end
        default: begin
          xor_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q     <= '0;
      sum_q     <= '0;
      tail_ok_q <= 1'b0;
    end else begin
      xor_q     <= xor_d;
      sum_q     <= sum_d;
      tail_ok_q <= tail_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o && op_i.kind == sfd_pkg::OP_DATA) begin
      store_q[op_i.idx] <= op_i.data;
    end
  end

endmodule

// ----- src/sensor_frame_deframer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame deframer
// Turns a received byte stream into sensor frames with a status per frame.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter through a queue-style port: a transfer happens at a clock edge
// with push high and full low. Each frame is two header bytes, twenty payload
// bytes, a checksum byte (XOR of the payload) and two tail bytes. On the last
// tail byte one result is queued: five little-endian payload words and a
// status (good, bad tail, bad checksum; the tail is checked first). A byte
// with buffer_end set sends the block back to header hunt after it.
// Results leave through a queue-style port: the oldest result shows while
// empty is low and is taken at an edge with pop high.
// One byte is taken every cycle while full is low. A result shows on the
// output ports once the op of its last tail byte has passed the op queue and
// the payload unit has queued the result; from then on it can be popped.
// When the receiver stalls, up to the result queue depth of results wait;
// then the payload unit stops at the next frame end, the op queue fills and
// full rises. Reset empties both queues, returns to header hunt and restores
// the header and tail registers to their default values.
// ----------------------------------------------------------------------------
module sensor_frame_deframer_unit #(
  parameter int OpQueueDepth  = sfd_pkg::OpQueueDepthDefault,
  parameter int ResQueueDepth = sfd_pkg::ResQueueDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  sfd_pkg::in_t                 in_data_i,
  output logic                         empty,
  input  logic                         pop,
  output sfd_pkg::out_t                out_data_o,
  input  logic                         cfg_we_i,
  input  logic [sfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [7:0]                   cfg_wdata_i
);

  logic [7:0] header_first_q, header_second_q, tail_first_q, tail_second_q;

  logic          in_take;
  logic          op_push, op_full, op_empty, op_pop;
  sfd_pkg::op_t  op_in, op_out;
  logic          res_push, res_full;
  sfd_pkg::out_t res_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_first_q  <= sfd_pkg::HeaderFirstReset;
      header_second_q <= sfd_pkg::HeaderSecondReset;
      tail_first_q    <= sfd_pkg::TailFirstReset;
      tail_second_q   <= sfd_pkg::TailSecondReset;
    end else if (cfg_we_i) begin
      case (sfd_pkg::cfg_idx_e'(cfg_idx_i))
        sfd_pkg::CFG_HEADER_FIRST:  header_first_q  <= cfg_wdata_i;
        sfd_pkg::CFG_HEADER_SECOND: header_second_q <= cfg_wdata_i;
        sfd_pkg::CFG_TAIL_FIRST:    tail_first_q    <= cfg_wdata_i;
        sfd_pkg::CFG_TAIL_SECOND:   tail_second_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign full    = op_full;
  assign in_take = push && !op_full;

  sfd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_take_i      (in_take),
    .in_data_i      (in_data_i),
    .header_first_i (header_first_q),
    .header_second_i(header_second_q),
    .op_valid_o     (op_push),
    .op_o           (op_in)
  );

  sfd_fifo #(
    .Width($bits(sfd_pkg::op_t)),
    .Depth(OpQueueDepth)
  ) u_op_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (op_push),
    .data_i (op_in),
    .full_o (op_full),
    .pop_i  (op_pop),
    .data_o (op_out),
    .empty_o(op_empty)
  );

  sfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (!op_empty),
    .op_i         (op_out),
    .op_pop_o     (op_pop),
    .tail_first_i (tail_first_q),
    .tail_second_i(tail_second_q),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  sfd_fifo #(
    .Width($bits(sfd_pkg::out_t)),
    .Depth(ResQueueDepth)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_data_o),
    .empty_o(empty)
  );

endmodule

// ----- src/sfd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame deframer checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          full,
  input  logic          empty,
  input  logic          pop,
  input  sfd_pkg::out_t out_data_o
);

  // Reset leaves the block with no result and room for input.
  a_reset_clean : assert property (@(posedge clk_i) !rst_ni |=> (empty && !full))
    else $error("Result pending or input blocked after reset.");

  // The status code never takes the unused value.
  a_status_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_data_o.frame_status == sfd_pkg::ST_GOOD ||
                out_data_o.frame_status == sfd_pkg::ST_BAD_TAIL ||
                out_data_o.frame_status == sfd_pkg::ST_BAD_SUM))
    else $error("Illegal frame status.");

  // A result that is not taken stays in place unchanged.
  a_result_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("Pending result changed without a transfer.");

  // Input backpressure only builds up while results are held back.
  a_full_needs_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(!empty))
    else $error("Input queue filled while no result was pending.");

endmodule

bind sensor_frame_deframer_unit sfd_checker u_sfd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_data_o(out_data_o)
);
